### hw/rtl/prefix_code_decoder_assert.svh
// Assertion macros shared by the prefix code decoder RTL.
`ifndef PREFIX_CODE_DECODER_ASSERT_SVH
`define PREFIX_CODE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/pcd_pkg.sv
// Package: shared constants and types of the prefix code decoder.
`default_nettype none

package pcd_pkg;

    localparam int unsigned MAX_CODE_LEN_DEF = 16;
    localparam int unsigned SYMBOL_COUNT_DEF = 256;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned SYM_W  = 8;
    localparam int unsigned CODE_W = 16;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned KIND_W = 2;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EOL  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SYMBOL   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE_END = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OVERLONG = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

### hw/rtl/pcd_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module pcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### hw/rtl/prefix_code_decoder.sv
// Top level: bit-serial prefix code decoder with a searched code table.
//
// channel | dir | tdata (low bit up)                               | tuser
// s_axis  | in  | entry_symbol 8, entry_code 16, entry_length 5,   | command 2
//         |     | code_bit 1, zero pad 2                           |
// m_axis  | out | decoded_symbol 8                                 | result_kind 2
//
// Load and unused beats are done at accept; end-of-line and overlong beats are
// accepted, then posted to the result register. A coded bit scans the table
// one entry a cycle from symbol 0, as the single table read port allows; a hit
// is then posted, a miss returns to idle. Input is not ready while a beat is
// in work. Reset (synchronous, active low) clears the state, the valid flags,
// the partial codeword and the result valid flag, not the result data. A
// stalled result holds the block in its post state.
`default_nettype none

module prefix_code_decoder
    import pcd_pkg::*;
#(
    parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // entry_symbol, entry_code, entry_length, code_bit
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // command
    input  wire logic [CMD_W-1:0]     i_s_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // decoded_symbol
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata,
    // result_kind
    output logic      [KIND_W-1:0]    o_m_axis_tuser
);

    `include "prefix_code_decoder_assert.svh"

    localparam int unsigned AW   = $clog2(SYMBOL_COUNT);
    localparam int unsigned PW   = MAX_CODE_LEN;
    localparam int unsigned PLW  = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned CMPW = (PW > CODE_W) ? PW : CODE_W;
    localparam int unsigned CMPL = (PLW > LEN_W) ? PLW : LEN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [PW-1:0]           r_bits, n_bits;
    logic [PLW-1:0]          r_plen, n_plen;
    logic [AW-1:0]           r_cmp_addr, n_cmp_addr;
    logic [SYMBOL_COUNT-1:0] r_valid;
    logic                    r_vld_q;
    logic [KIND_W-1:0]       r_res_kind, n_res_kind;
    logic [SYM_W-1:0]        r_res_sym, n_res_sym;
    logic                    r_m_valid;
    logic [KIND_W-1:0]       r_m_kind;
    logic [SYM_W-1:0]        r_m_sym;

    logic [CMD_W-1:0]  in_cmd;
    logic [SYM_W-1:0]  in_sym;
    logic [CODE_W-1:0] in_code;
    logic [LEN_W-1:0]  in_len;
    logic              in_bit;
    logic              accept;
    logic              do_load;
    logic [CODE_W-1:0] code_mask;
    t_entry            wr_entry;
    t_entry            rd_entry;
    logic [AW-1:0]     rd_addr;
    logic              last_addr;
    logic              hit;
    logic              slot_free;

    assign in_sym  = i_s_axis_tdata[SYM_W-1:0];
    assign in_code = i_s_axis_tdata[SYM_W +: CODE_W];
    assign in_len  = i_s_axis_tdata[SYM_W+CODE_W +: LEN_W];
    assign in_bit  = i_s_axis_tdata[SYM_W+CODE_W+LEN_W];
    assign in_cmd  = i_s_axis_tuser;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign do_load         = accept && (in_cmd == CMD_LOAD)
                             && ({1'b0, in_sym} < (SYM_W + 1)'(SYMBOL_COUNT));

    always_comb begin
        for (int j = 0; j < CODE_W; j++) begin
            code_mask[j] = (LEN_W'(j) < in_len);
        end
    end

    assign wr_entry.len  = in_len;
    assign wr_entry.code = in_code & code_mask;

    assign last_addr = (r_cmp_addr == AW'(SYMBOL_COUNT - 1));
    assign rd_addr   = (r_state == ST_SEARCH && !last_addr) ? r_cmp_addr + 1'b1 : '0;

    pcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (in_sym[AW-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    assign hit = r_vld_q
                 && (CMPL'(rd_entry.len) == CMPL'(r_plen))
                 && (CMPW'(rd_entry.code) == CMPW'(r_bits));

    assign slot_free = !r_m_valid || i_m_axis_tready;

    always_comb begin
        n_state    = r_state;
        n_bits     = r_bits;
        n_plen     = r_plen;
        n_cmp_addr = r_cmp_addr;
        n_res_kind = r_res_kind;
        n_res_sym  = r_res_sym;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_EOL) begin
                        n_bits     = '0;
                        n_plen     = '0;
                        n_res_kind = KIND_LINE_END;
                        n_res_sym  = '0;
                        n_state    = ST_EMIT;
                    end else if (in_cmd == CMD_BIT) begin
                        if (r_plen >= PLW'(MAX_CODE_LEN)) begin
                            n_bits     = '0;
                            n_plen     = '0;
                            n_res_kind = KIND_OVERLONG;
                            n_res_sym  = '0;
                            n_state    = ST_EMIT;
                        end else begin
                            n_bits     = PW'({r_bits, in_bit});
                            n_plen     = r_plen + 1'b1;
                            n_cmp_addr = '0;
                            n_state    = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH: begin
                if (hit) begin
                    n_bits     = '0;
                    n_plen     = '0;
                    n_res_kind = KIND_SYMBOL;
                    n_res_sym  = SYM_W'(r_cmp_addr);
                    n_state    = ST_EMIT;
                end else if (last_addr) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cmp_addr = r_cmp_addr + 1'b1;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bits    <= '0;
            r_plen    <= '0;
            r_valid   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bits  <= n_bits;
            r_plen  <= n_plen;
            if (do_load) begin
                r_valid[in_sym[AW-1:0]] <= (in_len != '0);
            end
            if (r_state == ST_EMIT && slot_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= n_cmp_addr;
        r_res_kind <= n_res_kind;
        r_res_sym  <= n_res_sym;
        r_vld_q    <= r_valid[rd_addr];
        if (r_state == ST_EMIT && slot_free) begin
            r_m_kind <= r_res_kind;
            r_m_sym  <= r_res_sym;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_sym;
    assign o_m_axis_tuser  = r_m_kind;

    `PCD_ASSERT_IMP(a_plen_bound, 1'b1, r_plen <= PLW'(MAX_CODE_LEN), "partial length overrun")
    `PCD_ASSERT_IMP(a_search_plen, r_state == ST_SEARCH, r_plen != '0, "search with empty codeword")
    `PCD_ASSERT_NXT(a_bit_starts, accept && in_cmd == CMD_BIT && r_plen < PLW'(MAX_CODE_LEN), r_state == ST_SEARCH && r_cmp_addr == '0, "bit beat did not start scan")
    `PCD_ASSERT_NXT(a_hit_clears, r_state == ST_SEARCH && hit, r_state == ST_EMIT && r_plen == '0 && r_res_kind == KIND_SYMBOL, "hit not posted")
    `PCD_ASSERT_NXT(a_emit_posts, r_state == ST_EMIT && slot_free, o_m_axis_tvalid && r_state == ST_IDLE, "result not posted")

endmodule

`default_nettype wire
